// ----- rtl/tmcq_pkg.sv -----
// Shared types and constants for the tile map collision query block.
// Cell layout, request and register codes, sequencer states.
// No dependencies.
package tmcq_pkg;

  localparam int TILE_PIXELS_DEF  = 32;
  localparam int MAX_MAP_SIDE_DEF = 64;

  // collision sizes above this never hit
  localparam int MAX_COLLISION = 16;

  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int MAP_W    = 7;    // map_width / map_height
  localparam int CELL_W   = 16;   // cell_x, cell_y, offsets
  localparam int RECT_W   = 21;   // rect_x, rect_y
  localparam int SIZE_W   = 10;   // rect_width, rect_height
  localparam int REND_W   = RECT_W + 1;

  typedef enum logic [2:0] {
    REQ_WRITE_CELL    = 3'd0,
    REQ_SET_LOWER     = 3'd1,
    REQ_SET_UPPER     = 3'd2,
    REQ_SET_COLLISION = 3'd3,
    REQ_READ_CELL     = 3'd4,
    REQ_QUERY         = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_X_OFFSET   = 2'd2,
    REG_Y_OFFSET   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] lower;
    logic [15:0] upper;
    logic [7:0]  effect;
    logic [7:0]  collision;
  } cell_t;

  typedef struct packed {
    logic lower;
    logic upper;
    logic effect;
    logic collision;
  } cell_mask_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_SUB,
    ST_CELL_MUL,
    ST_CELL_ACC,
    ST_QRY_DIV,
    ST_QRY_CLIP,
    ST_QRY_BASE,
    ST_QRY_WALK,
    ST_QRY_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/tile_map_collision_query.sv -----
// Tile map collision query: APB register file, tile store, request sequencer
// built around one shared registered multiplier. Depends on tmcq_pkg.
// Cell write/set/read: CELL_SUB, CELL_MUL, CELL_ACC, DONE; the next item is taken back in IDLE.
// Query: DIV, CLIP, BASE, then WALK with one store read per tile visited in the clipped rectangle,
//   then DRAIN; ends early at the first hit, goes to DONE if clipped empty. Unknown codes: DONE only.
// Reset: config registers to 0, then the store clears one cell per cycle, all DEPTH cells.
module tile_map_collision_query
  import tmcq_pkg::*;
#(
  parameter int TILE_PIXELS  = TILE_PIXELS_DEF,
  parameter int MAX_MAP_SIDE = MAX_MAP_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // requests
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               req_type,
  input  logic signed [CELL_W-1:0] cell_x,
  input  logic signed [CELL_W-1:0] cell_y,
  input  logic [15:0]              lower_value,
  input  logic [15:0]              upper_value,
  input  logic [7:0]               effect_value,
  input  logic [7:0]               collision_value,
  input  logic signed [RECT_W-1:0] rect_x,
  input  logic signed [RECT_W-1:0] rect_y,
  input  logic [SIZE_W-1:0]        rect_width,
  input  logic [SIZE_W-1:0]        rect_height,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              lower_out,
  output logic [15:0]              upper_out,
  output logic [7:0]               effect_out,
  output logic [7:0]               collision_out,
  output logic                     hit,
  output logic                     inside_map
);

  localparam int DEPTH = MAX_MAP_SIDE * MAX_MAP_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (AW > 2 * MAP_W) ? AW : 2 * MAP_W;

  // floor division by the tile size: bias to non-negative, multiply by reciprocal
  localparam int DIV_N       = 23;
  localparam int TP_LOG      = $clog2(TILE_PIXELS);
  localparam int DIV_S       = DIV_N + TP_LOG;
  localparam int DIV_BIAS_T  = ((1 << (RECT_W)) + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam int DIV_BIAS    = DIV_BIAS_T * TILE_PIXELS;
  localparam logic [63:0] RECIP =
    ((64'd1 << DIV_S) + 64'(TILE_PIXELS) - 64'd1) / 64'(TILE_PIXELS);
  localparam int MUL_W  = DIV_N + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int QW     = PROD_W - 1 - DIV_S;
  localparam int TC_W   = QW + 1;
  localparam int CL_W   = TC_W + 1;
  localparam int HALF   = TILE_PIXELS / 2;
  localparam int PIX_W  = REND_W + TP_LOG + 2;

  // ---------------- configuration ----------------
  logic [MAP_W-1:0]        map_width, map_height;
  logic signed [CELL_W-1:0] x_offset, y_offset;
  logic [MAP_W-1:0]        ew, eh;
  logic                    cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= '0;
      map_height <= '0;
      x_offset   <= '0;
      y_offset   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MAP_WIDTH:  map_width  <= pwdata[MAP_W-1:0];
        REG_MAP_HEIGHT: map_height <= pwdata[MAP_W-1:0];
        REG_X_OFFSET:   x_offset   <= pwdata[CELL_W-1:0];
        REG_Y_OFFSET:   y_offset   <= pwdata[CELL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MAP_WIDTH:  prdata = {{(PDATA_W-MAP_W){1'b0}}, map_width};
      REG_MAP_HEIGHT: prdata = {{(PDATA_W-MAP_W){1'b0}}, map_height};
      REG_X_OFFSET:   prdata = {{(PDATA_W-CELL_W){1'b0}}, x_offset};
      REG_Y_OFFSET:   prdata = {{(PDATA_W-CELL_W){1'b0}}, y_offset};
    endcase
  end

  assign ew = ({2'b00, map_width}  > 9'(MAX_MAP_SIDE)) ? MAP_W'(MAX_MAP_SIDE) : map_width;
  assign eh = ({2'b00, map_height} > 9'(MAX_MAP_SIDE)) ? MAP_W'(MAX_MAP_SIDE) : map_height;

  // ---------------- state ----------------
  state_t state, state_next;
  logic [2:0] step, step_next;
  logic [AW-1:0] clr_addr;
  logic clr_last;
  logic load_out;

  // captured request
  logic [2:0]               req_q;
  logic signed [CELL_W-1:0] cell_x_q, cell_y_q;
  logic [15:0]              lower_q, upper_q;
  logic [7:0]               effect_q, coll_q;
  logic signed [RECT_W-1:0] rx_q, ry_q;
  logic signed [REND_W-1:0] rx_end, ry_end;

  // result staging
  logic res_hit, res_inside, res_read;

  // cell addressing
  logic signed [CELL_W:0] col_d, row_d;
  logic                   inside_d;
  logic [MAP_W-1:0]       cell_col, cell_row;
  logic [IDX_W-1:0]       cell_sum;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [TC_W-1:0]   tile_q;

  // query walk
  logic signed [TC_W-1:0] tile_x0, tile_x1, tile_y0, tile_y1;
  logic signed [CL_W-1:0] col0, col1, row0, row1, col0c, col1c, row0c, row1c;
  logic signed [CL_W-1:0] ew_m1, eh_m1;
  logic                   clip_empty;
  logic [MAP_W-1:0]       col_first, col_last, row_first, row_last, col, row;
  logic signed [CELL_W:0] tile_x_first, tile_y_first;
  logic signed [PIX_W-1:0] xl_first, xr_first, xl_cur, xr_cur, yl_cur, yr_cur;
  logic signed [PIX_W-1:0] xl_new, xr_new, yl_new, yr_new;
  logic signed [PIX_W-1:0] t_xl, t_xr, t_yl, t_yr, coll_s;
  logic                   t_valid, tile_hit, walk_last;
  logic [IDX_W-1:0]       rowbase, walk_sum;

  // store
  cell_t           mem [DEPTH];
  cell_t           rd_data, mem_wdata;
  cell_mask_t      mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;

  assign in_stall = (state != ST_IDLE);
  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  // ---------------- combinational datapath ----------------
  assign col_d    = (CELL_W+1)'(cell_x_q) - (CELL_W+1)'(x_offset);
  assign row_d    = (CELL_W+1)'(cell_y_q) - (CELL_W+1)'(y_offset);
  assign inside_d = !col_d[CELL_W] && ($unsigned(col_d) < (CELL_W+1)'(ew)) &&
                    !row_d[CELL_W] && ($unsigned(row_d) < (CELL_W+1)'(eh));
  assign cell_sum = prod[IDX_W-1:0] + IDX_W'(cell_col);

  assign tile_q = signed'({1'b0, prod[PROD_W-2:DIV_S]}) - TC_W'(DIV_BIAS_T);

  assign ew_m1 = CL_W'(signed'({1'b0, ew})) - CL_W'(1);
  assign eh_m1 = CL_W'(signed'({1'b0, eh})) - CL_W'(1);
  assign col0  = CL_W'(tile_x0) - CL_W'(x_offset);
  assign col1  = CL_W'(tile_x1) - CL_W'(x_offset);
  assign row0  = CL_W'(tile_y0) - CL_W'(y_offset);
  assign row1  = CL_W'(tile_y1) - CL_W'(y_offset);
  assign col0c = col0[CL_W-1] ? '0 : col0;
  assign row0c = row0[CL_W-1] ? '0 : row0;
  assign col1c = (col1 > ew_m1) ? ew_m1 : col1;
  assign row1c = (row1 > eh_m1) ? eh_m1 : row1;
  // an empty map gives a last index of -1, so it falls out here too
  assign clip_empty = (col0c > col1c) || (row0c > row1c);

  assign tile_x_first = (CELL_W+1)'(x_offset) + (CELL_W+1)'(signed'({1'b0, col_first}));
  assign tile_y_first = (CELL_W+1)'(y_offset) + (CELL_W+1)'(signed'({1'b0, row_first}));

  // per-axis distances against the tile center px: overlap iff both are below c
  assign xl_new = PIX_W'(prod) + PIX_W'(HALF) - PIX_W'(rx_end);
  assign xr_new = PIX_W'(rx_q) - PIX_W'(prod) - PIX_W'(HALF);
  assign yl_new = PIX_W'(prod) + PIX_W'(HALF) - PIX_W'(ry_end);
  assign yr_new = PIX_W'(ry_q) - PIX_W'(prod) - PIX_W'(HALF);

  assign walk_sum  = rowbase + IDX_W'(col);
  assign walk_last = (col == col_last) && (row == row_last);

  assign coll_s   = PIX_W'(signed'({1'b0, rd_data.collision}));
  assign tile_hit = t_valid && (rd_data.collision != 8'd0) &&
                    (rd_data.collision <= 8'(MAX_COLLISION)) &&
                    (t_xl < coll_s) && (t_xr < coll_s) &&
                    (t_yl < coll_s) && (t_yr < coll_s);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mul_a      = '0;
    mul_b      = '0;
    mem_we     = '0;
    mem_re     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '{lower: lower_q, upper: upper_q, effect: effect_q, collision: coll_q};
    load_out   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = '1;
        mem_wdata = '0;
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          if (req_type == REQ_QUERY)          state_next = ST_QRY_DIV;
          else if (req_type <= REQ_READ_CELL) state_next = ST_CELL_SUB;
          else                                state_next = ST_DONE;
        end
      end
      ST_CELL_SUB: state_next = ST_CELL_MUL;
      ST_CELL_MUL: begin
        mul_a      = MUL_W'({1'b0, cell_row});
        mul_b      = MUL_W'({1'b0, ew});
        state_next = ST_CELL_ACC;
      end
      ST_CELL_ACC: begin
        mem_addr = cell_sum[AW-1:0];
        if (res_inside) begin
          unique case (req_q)
            REQ_WRITE_CELL:    mem_we = '1;
            REQ_SET_LOWER:     mem_we.lower = 1'b1;
            REQ_SET_UPPER:     mem_we.upper = 1'b1;
            REQ_SET_COLLISION: mem_we.collision = 1'b1;
            REQ_READ_CELL:     mem_re = 1'b1;
            default:           mem_we = '0;
          endcase
        end
        state_next = ST_DONE;
      end
      ST_QRY_DIV: begin
        case (step)
          3'd0:    mul_a = MUL_W'(rx_q) + MUL_W'(DIV_BIAS);
          3'd1:    mul_a = MUL_W'(rx_end) + MUL_W'(DIV_BIAS);
          3'd2:    mul_a = MUL_W'(ry_q) + MUL_W'(DIV_BIAS);
          3'd3:    mul_a = MUL_W'(ry_end) + MUL_W'(DIV_BIAS);
          default: mul_a = '0;
        endcase
        mul_b     = MUL_W'(RECIP);
        step_next = step + 3'd1;
        if (step == 3'd4) state_next = ST_QRY_CLIP;
      end
      ST_QRY_CLIP: begin
        step_next  = '0;
        state_next = clip_empty ? ST_DONE : ST_QRY_BASE;
      end
      ST_QRY_BASE: begin
        case (step)
          3'd0: begin
            mul_a = MUL_W'(tile_x_first);
            mul_b = MUL_W'(TILE_PIXELS);
          end
          3'd1: begin
            mul_a = MUL_W'(tile_y_first);
            mul_b = MUL_W'(TILE_PIXELS);
          end
          3'd2: begin
            mul_a = MUL_W'({1'b0, row_first});
            mul_b = MUL_W'({1'b0, ew});
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
        step_next = step + 3'd1;
        if (step == 3'd3) state_next = ST_QRY_WALK;
      end
      ST_QRY_WALK: begin
        mem_addr = walk_sum[AW-1:0];
        mem_re   = 1'b1;
        if (tile_hit)       state_next = ST_DONE;
        else if (walk_last) state_next = ST_QRY_DRAIN;
      end
      ST_QRY_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      t_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      t_valid <= (state == ST_QRY_WALK);
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // ---------------- shared multiplier ----------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req_q      <= req_type;
      cell_x_q   <= cell_x;
      cell_y_q   <= cell_y;
      lower_q    <= lower_value;
      upper_q    <= upper_value;
      effect_q   <= effect_value;
      coll_q     <= collision_value;
      rx_q       <= rect_x;
      ry_q       <= rect_y;
      rx_end     <= REND_W'(rect_x) + REND_W'(signed'({1'b0, rect_width}));
      ry_end     <= REND_W'(rect_y) + REND_W'(signed'({1'b0, rect_height}));
      res_hit    <= 1'b0;
      res_inside <= 1'b0;
      res_read   <= 1'b0;
    end

    if (state == ST_CELL_SUB) begin
      cell_col   <= col_d[MAP_W-1:0];
      cell_row   <= row_d[MAP_W-1:0];
      res_inside <= inside_d;
    end

    if (state == ST_CELL_ACC) res_read <= res_inside && (req_q == REQ_READ_CELL);

    if (state == ST_QRY_DIV) begin
      case (step)
        3'd1:    tile_x0 <= tile_q;
        3'd2:    tile_x1 <= tile_q;
        3'd3:    tile_y0 <= tile_q;
        3'd4:    tile_y1 <= tile_q;
        default: tile_x0 <= tile_x0;
      endcase
    end

    if (state == ST_QRY_CLIP) begin
      col_first <= col0c[MAP_W-1:0];
      col_last  <= col1c[MAP_W-1:0];
      row_first <= row0c[MAP_W-1:0];
      row_last  <= row1c[MAP_W-1:0];
    end

    if (state == ST_QRY_BASE) begin
      case (step)
        3'd1: begin
          xl_first <= xl_new;
          xr_first <= xr_new;
          xl_cur   <= xl_new;
          xr_cur   <= xr_new;
        end
        3'd2: begin
          yl_cur <= yl_new;
          yr_cur <= yr_new;
        end
        3'd3: begin
          rowbase <= prod[IDX_W-1:0];
          col     <= col_first;
          row     <= row_first;
        end
        default: rowbase <= rowbase;
      endcase
    end

    if (state == ST_QRY_WALK) begin
      // tile tag travels alongside the store read
      t_xl <= xl_cur;
      t_xr <= xr_cur;
      t_yl <= yl_cur;
      t_yr <= yr_cur;
      if (col == col_last) begin
        col     <= col_first;
        xl_cur  <= xl_first;
        xr_cur  <= xr_first;
        row     <= row + MAP_W'(1);
        yl_cur  <= yl_cur + PIX_W'(TILE_PIXELS);
        yr_cur  <= yr_cur - PIX_W'(TILE_PIXELS);
        rowbase <= rowbase + IDX_W'(ew);
      end else begin
        col    <= col + MAP_W'(1);
        xl_cur <= xl_cur + PIX_W'(TILE_PIXELS);
        xr_cur <= xr_cur - PIX_W'(TILE_PIXELS);
      end
    end

    if ((state == ST_QRY_WALK || state == ST_QRY_DRAIN) && tile_hit) res_hit <= 1'b1;
  end

  // ---------------- tile store ----------------
  always_ff @(posedge clk) begin
    if (mem_we.lower)     mem[mem_addr].lower     <= mem_wdata.lower;
    if (mem_we.upper)     mem[mem_addr].upper     <= mem_wdata.upper;
    if (mem_we.effect)    mem[mem_addr].effect    <= mem_wdata.effect;
    if (mem_we.collision) mem[mem_addr].collision <= mem_wdata.collision;
    if (mem_re)           rd_data <= mem[mem_addr];
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (load_out) begin
      lower_out     <= res_read ? rd_data.lower     : '0;
      upper_out     <= res_read ? rd_data.upper     : '0;
      effect_out    <= res_read ? rd_data.effect    : '0;
      collision_out <= res_read ? rd_data.collision : '0;
      hit           <= res_hit;
      inside_map    <= res_inside;
    end
  end

endmodule

// ----- rtl/tmcq_checker.sv -----
// Port-level checks for the tile map collision query block.
// Bound to tile_map_collision_query; sees its ports only.
module tmcq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] lower_out,
  input logic [15:0] upper_out,
  input logic [7:0]  effect_out,
  input logic [7:0]  collision_out,
  input logic        hit,
  input logic        inside_map
);

  // store clearing keeps the input stalled through and right after reset
  a_stall_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

  // one item at a time: a transfer is followed by a busy cycle
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // hit comes only from queries, inside_map only from cell requests
  a_hit_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && inside_map))
    else $error("hit and inside_map both set");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_map |->
      lower_out == 16'd0 && upper_out == 16'd0 &&
      effect_out == 8'd0 && collision_out == 8'd0)
    else $error("cell contents on a result outside the map");

endmodule

bind tile_map_collision_query tmcq_checker u_tmcq_checker (.*);
